// ===== rtl/core/isl_pkg.sv =====
// Shared types and codes for the indexed shift list.
`timescale 1ns / 1ps

package isl_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // open a slot at the index, higher cells take the lower neighbor
    logic del;  // close the slot at the index, cells at or above take the upper neighbor
  } shift_ctrl_t;

endpackage

// ===== rtl/core/isl_cell.sv =====
// One storage cell of the shift row: holds one word, loads from a neighbor or the new word.
`timescale 1ns / 1ps

module isl_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  isl_pkg::shift_ctrl_t      ctrl,
  input  logic [IW-1:0]             at,
  input  logic [isl_pkg::WORD_W-1:0] word,
  input  logic [isl_pkg::WORD_W-1:0] lower,
  input  logic [isl_pkg::WORD_W-1:0] upper,
  output logic [isl_pkg::WORD_W-1:0] data
);
  import isl_pkg::*;

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (ctrl.ins) begin
      if (IDX > at) begin
        data <= lower;
      end else if (IDX == at) begin
        data <= word;
      end
    end else if (ctrl.del) begin
      if (IDX >= at) begin
        data <= upper;
      end
    end
  end

endmodule

// ===== rtl/core/indexed_shift_list.sv =====
// Top level of the indexed shift list: operation decode, cell row, count and result register.
//
//  channel | dir | fields (tdata, low bit first)
//  --------+-----+------------------------------------------------------------------
//  s_*     | in  | operation[2:0], position[6:3], value[38:7], zero pad [39]
//  m_*     | out | read_data[31:0], count[36:32], status[38:37], zero pad [39]
//
// One transaction per cycle while the result is taken: every cell loads its neighbor, the new word or
// itself in the accept cycle, and the result is written into the output register at the same clock edge.
// s_tready is high while the result register is empty or being taken.
// rst (synchronous) clears all cells, the count and the output valid.
// A stalled result holds m_tdata and blocks further input.
`timescale 1ns / 1ps

module indexed_shift_list #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[2:0], position[6:3], value[38:7]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_data[31:0], count[36:32], status[38:37]
);
  import isl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (IW > 4) ? IW : 4;
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int OW = (CW > 5) ? CW : 5;

  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic [WORD_W-1:0] cell_data [CAPACITY];

  logic [2:0]        in_op;
  logic [3:0]        in_pos;
  logic [WORD_W-1:0] in_value;

  logic              accept;
  shift_ctrl_t       ctrl;
  logic              do_ins;
  logic              do_del;
  logic [IW-1:0]     at;
  logic [PW-1:0]     pos_w;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic              full;
  logic              empty;
  logic [WORD_W-1:0] rd;
  status_t           st;
  logic [OW-1:0]     cnt_o;

  logic [WORD_W-1:0] out_rd;
  logic [4:0]        out_cnt;
  status_t           out_st;

  assign in_op    = s_tdata[2:0];
  assign in_pos   = s_tdata[6:3];
  assign in_value = s_tdata[38:7];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign pos_w = PW'(in_pos);
  assign pos_x = XW'(in_pos);
  assign cnt_x = XW'(cnt);
  assign full  = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    at     = '0;
    rd     = '0;
    st     = ST_OK;
    unique case (in_op)
      OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
          at     = cnt[IW-1:0];
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          at     = IW'(cnt - CW'(1));
        end
      end
      OP_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos_x > cnt_x) begin
          st = ST_RANGE;
        end else begin
          do_ins = 1'b1;
          at     = pos_w[IW-1:0];
        end
      end
      OP_ERASE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ST_RANGE;
        end else begin
          do_del = 1'b1;
          at     = pos_w[IW-1:0];
        end
      end
      OP_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ST_RANGE;
        end else begin
          rd = cell_data[pos_w[IW-1:0]];
        end
      end
      default: st = ST_RANGE;
    endcase
  end

  assign ctrl.ins = accept && do_ins;
  assign ctrl.del = accept && do_del;

  always_comb begin
    cnt_next = cnt;
    if (do_ins) begin
      cnt_next = cnt + CW'(1);
    end else if (do_del) begin
      cnt_next = cnt - CW'(1);
    end
  end

  assign cnt_o = OW'(cnt_next);

  // Row of cells; the ends see zero, which keeps slots past the count cleared.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    if (k == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[k+1];
    end
    isl_cell #(
      .IW    (IW),
      .INDEX (k)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .at    (at),
      .word  (in_value),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd  <= rd;
      out_cnt <= cnt_o[4:0];
      out_st  <= st;
    end
  end

  assign m_tdata = {1'b0, out_st, out_cnt, out_rd};

  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (cnt != CW'(CAPACITY)) |-> (cell_data[cnt[IW-1:0]] == '0))
    else $error("slot past the count not cleared");

  assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == OP_APPEND) && !full) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("append did not grow the count");

  assert property (@(posedge clk) disable iff (rst)
    (accept && (st != ST_OK)) |=> (cnt == $past(cnt)))
    else $error("failed transaction changed the count");

endmodule

// ===== dv/indexed_shift_list_tb.sv =====
// Self-checking testbench for the indexed shift list: stream driver, result monitor, list predictor.
`timescale 1ns / 1ps

module indexed_shift_list_tb;
  import isl_pkg::*;

  localparam int CAP = 16;
  localparam int RANDOM_OPS = 1920;
  localparam int SYNC_EVERY = 480;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 60;
  // codes above OP_READ are unused and must report a range error
  localparam logic [2:0] OP_LAST_CODE = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  pos;
    logic [31:0] word;
    bit          sync;   // sender waits for all replies before offering this one
  } list_op_t;

  typedef struct {
    logic [31:0] rd;
    logic [4:0]  cnt;
    status_t     st;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // operation[2:0], position[6:3], value[38:7], pad[39]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // read_data[31:0], count[36:32], status[38:37], pad[39]

  list_op_t     pending_ops[$];
  list_result_t predicted_replies[$];
  list_op_t     offered_op;

  // predictor state
  logic [31:0] slots[CAP];
  int          fill;

  int error_count = 0;
  int cycle_count = 0;
  int ops_taken = 0;
  int replies_seen = 0;
  int send_wait = 0;
  int recv_wait = 0;

  indexed_shift_list #(.CAPACITY(CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic void open_slot(int at, logic [31:0] word);
    for (int k = fill; k > at; k--) slots[k] = slots[k - 1];
    slots[at] = word;
    fill++;
  endfunction

  function automatic void close_slot(int at);
    for (int k = at; k + 1 < fill; k++) slots[k] = slots[k + 1];
    fill--;
    slots[fill] = '0;
  endfunction

  function automatic list_result_t apply_list_op(list_op_t t);
    list_result_t r;
    r.rd = '0;
    r.st = ST_OK;
    case (t.op)
      OP_APPEND: begin
        if (fill >= CAP) r.st = ST_FULL;
        else open_slot(fill, t.word);
      end
      OP_REMOVE: begin
        if (fill == 0) r.st = ST_EMPTY;
        else close_slot(fill - 1);
      end
      OP_INSERT: begin
        if (fill >= CAP) r.st = ST_FULL;
        else if (int'(t.pos) > fill) r.st = ST_RANGE;
        else open_slot(t.pos, t.word);
      end
      OP_ERASE: begin
        if (fill == 0) r.st = ST_EMPTY;
        else if (int'(t.pos) >= fill) r.st = ST_RANGE;
        else close_slot(t.pos);
      end
      OP_READ: begin
        if (fill == 0) r.st = ST_EMPTY;
        else if (int'(t.pos) >= fill) r.st = ST_RANGE;
        else r.rd = slots[t.pos];
      end
      default: r.st = ST_RANGE;
    endcase
    r.cnt = 5'(fill);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] reply %0d: %s got 0x%0h want 0x%0h", $realtime, replies_seen, what, got, want);
    error_count++;
  endtask

  task automatic queue_op(logic [2:0] op, logic [3:0] pos, logic [31:0] word, bit sync);
    list_op_t t;
    t.op = op;
    t.pos = pos;
    t.word = word;
    t.sync = sync;
    pending_ops.push_back(t);
  endtask

  // stimulus: directed corners, then random runs that swing between empty and full
  initial begin
    int gen_fill;
    int roll;
    int hi;
    bit growing;
    logic [2:0] op;
    logic [3:0] pos;
    logic [31:0] word;

    for (int k = 0; k < CAP; k++) slots[k] = '0;
    fill = 0;

    queue_op(OP_READ, 4'd0, 32'h0, 1'b0);
    queue_op(OP_REMOVE, 4'd0, 32'h0, 1'b0);
    queue_op(OP_ERASE, 4'd0, 32'h0, 1'b0);
    queue_op(OP_INSERT, 4'd1, 32'h1234_5678, 1'b0);   // past the end of an empty list
    for (int c = int'(OP_READ) + 1; c <= int'(OP_LAST_CODE); c++)
      queue_op(3'(c), 4'hF, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_INSERT, 4'd0, 32'h7FFF_FFFF, 1'b0);
    queue_op(OP_APPEND, 4'd0, 32'h8000_0000, 1'b0);
    queue_op(OP_INSERT, 4'd2, 32'hFFFF_FFFF, 1'b0);   // index equal to count appends
    queue_op(OP_INSERT, 4'd1, 32'h0, 1'b0);
    queue_op(OP_READ, 4'd3, 32'h0, 1'b0);
    queue_op(OP_READ, 4'd4, 32'h0, 1'b0);
    queue_op(OP_ERASE, 4'd4, 32'h0, 1'b0);
    queue_op(OP_ERASE, 4'd1, 32'h0, 1'b0);
    queue_op(OP_REMOVE, 4'd0, 32'h0, 1'b0);
    for (int k = 2; k < CAP; k++) queue_op(OP_APPEND, 4'd0, $urandom, 1'b0);
    queue_op(OP_APPEND, 4'd0, 32'hA5A5_A5A5, 1'b0);
    queue_op(OP_INSERT, 4'd15, 32'h5A5A_5A5A, 1'b0);  // insert on a full list reports full
    queue_op(OP_READ, 4'd15, 32'h0, 1'b0);
    queue_op(OP_ERASE, 4'd15, 32'h0, 1'b0);
    queue_op(OP_ERASE, 4'd0, 32'h0, 1'b0);
    gen_fill = CAP - 2;

    growing = 1'b0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) op = 3'(OP_LAST_CODE - $urandom_range(0, 2));
      else if (roll < 25) op = OP_READ;
      else if (growing == (roll < 75)) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      else op = $urandom_range(0, 1) ? OP_REMOVE : OP_ERASE;

      hi = (op == OP_INSERT) ? gen_fill : gen_fill - 1;
      if (hi > CAP - 1) hi = CAP - 1;
      if (hi < 0) hi = 0;
      if ($urandom_range(0, 9) == 0) pos = 4'($urandom_range(0, 15));
      else pos = 4'($urandom_range(0, hi));

      case ($urandom_range(0, 7))
        0: word = 32'h8000_0000;
        1: word = 32'h7FFF_FFFF;
        2: word = '1;
        3: word = '0;
        default: word = $urandom;
      endcase

      queue_op(op, pos, word, (n % SYNC_EVERY) == 0);

      if (gen_fill < CAP && (op == OP_APPEND || (op == OP_INSERT && int'(pos) <= gen_fill)))
        gen_fill++;
      else if (gen_fill > 0 && (op == OP_REMOVE || (op == OP_ERASE && int'(pos) < gen_fill)))
        gen_fill--;

      if ((gen_fill == CAP && growing && $urandom_range(0, 3) == 0) ||
          (gen_fill == 0 && !growing && $urandom_range(0, 3) == 0) ||
          $urandom_range(0, 39) == 0)
        growing = !growing;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("indexed_shift_list verification clean");
    end else begin
      $display("indexed_shift_list verification failed");
    end
    $finish;
  end

  // driver: predicts on acceptance, then offers the next op after its drawn gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_replies.push_back(apply_list_op(offered_op));
        ops_taken++;
        // idle stretches alternate with back-to-back stretches
        send_wait = ((ops_taken / 100) % 3 != 0) ? $urandom_range(0, 8) : 0;
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].sync && predicted_replies.size() != 0)) begin
          offered_op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, offered_op.word, offered_op.pos, offered_op.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each reply transaction against the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          report_mismatch("unexpected reply", m_tdata, 0);
        end else begin
          want = predicted_replies.pop_front();
          if (m_tdata[31:0] !== want.rd) report_mismatch("read_data", m_tdata[31:0], want.rd);
          if (m_tdata[36:32] !== want.cnt) report_mismatch("count", m_tdata[36:32], want.cnt);
          if (m_tdata[38:37] !== want.st) report_mismatch("status", m_tdata[38:37], want.st);
        end
        recv_wait = ((replies_seen / 128) % 3 != 0) ? $urandom_range(0, 8) : 0;
        // long back-pressure so the input side stalls while ops keep coming
        if (replies_seen == 300 || replies_seen == 1200) recv_wait = LONG_HOLD;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_shift_list verification failed");
      $finish;
    end
  end

endmodule
